[src/assert_macros.svh]
// Shared assertion macros. The including module must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/lrl_pkg.sv]
package lrl_pkg;

    localparam int KEY_W      = 5;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 5;
    localparam int CAP_W      = 5;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LIST   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_CREATED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_KEY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 2'd3;

    localparam logic [CAP_W-1:0] MIN_CAPACITY = 5'd5;
    localparam logic [KEY_W-1:0] LAST_KEY     = 5'd25;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic                evicted;
        logic [KEY_W-1:0]    evicted_key;
        logic [KEY_W-1:0]    list_key;
        logic                last;
    } t_rsp;

endpackage

[src/lrl_if.sv]
interface lrl_req_if;
    import lrl_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lrl_rsp_if;
    import lrl_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/lru_recency_list.sv]
// LRU recency list of up to MAX_ENTRIES letter keys, most recent first.
// Requests arrive on i_req (command, key) with a valid/ready handshake and
// results leave on o_rsp through an output register; every request except
// list and the unused codes gives exactly one result, marked last.
// The capacity register is written through i_cfg_we/i_cfg_wdata; the user
// must write it only while the block is idle (the block does not enforce
// this). A write also empties the list. The keys sit in a single-port-write,
// registered-read RAM that a small sequencer walks one entry per cycle.
// i_req.ready is high only when the sequencer is idle. Flush, error answers
// and unused codes need no walk. Get makes a find pass, then a rotate pass
// to the hit. List emits one key per cycle while the receiver takes them.
// A finished result waits in a pending register until the output register
// is free. While the output register holds a result and o_rsp.ready is low,
// the pending result holds and the sequencer waits; a list pauses on its
// current key. Reset leaves the list empty and the capacity at zero, so the
// cache reads as not created until it is written.
`include "assert_macros.svh"

module lru_recency_list #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lrl_req_if.sink              i_req,
    lrl_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [lrl_pkg::CAP_W-1:0] i_cfg_wdata
);
    import lrl_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int OW = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_ROT    = 3'd2;
    localparam logic [2:0] S_TAIL   = 3'd3;
    localparam logic [2:0] S_LIST   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [KEY_W-1:0] r_key, n_key;
    logic [AW-1:0]    r_cur, n_cur;
    logic [KEY_W-1:0] r_carry, n_carry;
    logic [OW-1:0]    r_occ, n_occ;
    logic [CAP_W-1:0] r_cap, n_cap;
    t_rsp             r_pend, n_pend;
    t_rsp             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [KEY_W-1:0] ram_rdata;

    logic             created;
    logic             out_free;
    logic             hit;
    logic             cur_last;
    logic [AW-1:0]    cur_inc;
    logic [POS_W-1:0] pos_cur;
    logic             in_pass;
    logic             flush_take;

    function automatic t_rsp f_done(input logic [STATUS_W-1:0] st,
                                    input logic [POS_W-1:0] pos,
                                    input logic ev,
                                    input logic [KEY_W-1:0] evk);
        t_rsp r;
        r.status      = st;
        r.position    = pos;
        r.evicted     = ev;
        r.evicted_key = evk;
        r.list_key    = '0;
        r.last        = 1'b1;
        return r;
    endfunction

    lrl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_order (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign created  = (r_cap >= MIN_CAPACITY) && (32'(r_cap) <= 32'(MAX_ENTRIES));
    assign out_free = !r_out_valid || o_rsp.ready;
    assign hit      = (ram_rdata == r_key);
    assign cur_last = (OW'(r_cur) == (r_occ - OW'(1)));
    assign cur_inc  = r_cur + AW'(1);
    assign pos_cur  = POS_W'(32'(r_cur) + 1);

    assign in_pass    = (r_state == S_FIND) || (r_state == S_ROT) || (r_state == S_LIST);
    assign flush_take = i_req.valid && i_req.ready && (i_req.data.command == CMD_FLUSH);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_cur       = r_cur;
        n_carry     = r_carry;
        n_occ       = r_occ;
        n_cap       = r_cap;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        ram_we      = 1'b0;
        ram_waddr   = r_cur;
        ram_wdata   = r_carry;
        ram_raddr   = cur_inc;

        case (r_state)
            S_IDLE: begin
                ram_raddr = '0;
                if (i_req.valid) begin
                    n_cmd = i_req.data.command;
                    n_key = i_req.data.key;
                    n_cur = '0;
                    case (i_req.data.command)
                        CMD_FLUSH: begin
                            n_occ   = '0;
                            n_pend  = f_done(ST_OK, '0, 1'b0, '0);
                            n_state = S_RESULT;
                        end
                        CMD_ADD, CMD_GET, CMD_SEARCH, CMD_LIST: begin
                            if (!created) begin
                                n_pend  = f_done(ST_NOT_CREATED, '0, 1'b0, '0);
                                n_state = S_RESULT;
                            end else if (i_req.data.command == CMD_LIST) begin
                                if (r_occ == '0) begin
                                    n_pend  = f_done(ST_OK, '0, 1'b0, '0);
                                    n_state = S_RESULT;
                                end else begin
                                    n_state = S_LIST;
                                end
                            end else if (i_req.data.key > LAST_KEY) begin
                                n_pend  = f_done(ST_BAD_KEY, '0, 1'b0, '0);
                                n_state = S_RESULT;
                            end else if (i_req.data.command == CMD_ADD) begin
                                n_pend = f_done(ST_OK, POS_W'(1), 1'b0, '0);
                                if (r_occ == '0) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = '0;
                                    ram_wdata = i_req.data.key;
                                    n_occ     = OW'(1);
                                    n_state   = S_RESULT;
                                end else begin
                                    n_carry = i_req.data.key;
                                    n_state = S_ROT;
                                end
                            end else if (r_occ == '0) begin
                                n_pend  = f_done(ST_NOT_FOUND, '0, 1'b0, '0);
                                n_state = S_RESULT;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (hit) begin
                    if (r_cmd == CMD_GET) begin
                        ram_raddr = '0;
                        n_cur     = '0;
                        n_carry   = r_key;
                        n_state   = S_ROT;
                    end else begin
                        n_pend  = f_done(ST_OK, pos_cur, 1'b0, '0);
                        n_state = S_RESULT;
                    end
                end else if (cur_last) begin
                    n_pend  = f_done(ST_NOT_FOUND, '0, 1'b0, '0);
                    n_state = S_RESULT;
                end else begin
                    n_cur = cur_inc;
                end
            end
            S_ROT: begin
                // Each entry takes the key ahead of it until the requested key or the end of the list is reached.
                ram_we  = 1'b1;
                n_carry = ram_rdata;
                if (hit) begin
                    n_pend  = f_done(ST_OK, POS_W'(1), 1'b0, '0);
                    n_state = S_RESULT;
                end else if (cur_last) begin
                    if (32'(r_occ) >= 32'(r_cap)) begin
                        n_pend  = f_done(ST_OK, POS_W'(1), 1'b1, ram_rdata);
                        n_state = S_RESULT;
                    end else begin
                        n_cur   = cur_inc;
                        n_occ   = r_occ + OW'(1);
                        n_pend  = f_done(ST_OK, POS_W'(1), 1'b0, '0);
                        n_state = S_TAIL;
                    end
                end else begin
                    n_cur = cur_inc;
                end
            end
            S_TAIL: begin
                ram_we  = 1'b1;
                n_state = S_RESULT;
            end
            S_LIST: begin
                ram_raddr = out_free ? cur_inc : r_cur;
                if (out_free) begin
                    n_out.status      = ST_OK;
                    n_out.position    = pos_cur;
                    n_out.evicted     = 1'b0;
                    n_out.evicted_key = '0;
                    n_out.list_key    = ram_rdata;
                    n_out.last        = cur_last;
                    n_out_valid       = 1'b1;
                    if (cur_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur = cur_inc;
                    end
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_cap = i_cfg_wdata;
            n_occ = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_cap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_cur   <= n_cur;
        r_carry <= n_carry;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    `ASSERT_SAME(a_occ_within_cap, created, 32'(r_occ) <= 32'(r_cap))
    `ASSERT_SAME(a_pass_in_range, in_pass, r_occ != '0 && OW'(r_cur) < r_occ)
    `ASSERT_NEXT(a_flush_empties, flush_take, r_occ == '0 && r_state == S_RESULT)

endmodule

[src/lrl_ram.sv]
module lrl_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[bench/lru_recency_checker.sv]
`timescale 1ns / 1ps

module lru_recency_checker #(
    parameter int MAX_KEYS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lrl_req_if                i_req,
    lrl_rsp_if                i_rsp,
    input  logic              i_cfg_we,
    input  logic [lrl_pkg::CAP_W-1:0] i_cfg_wdata,
    output int                o_errors,
    output int                o_outstanding
);
    import lrl_pkg::*;

    logic [KEY_W-1:0] order_keys [MAX_KEYS];
    int               held_count;
    logic [CAP_W-1:0] capacity;
    t_rsp             pending_answers [$];
    int               mismatch_count = 0;

    assign o_errors = mismatch_count;

    task automatic report_failure(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void move_to_front(input int idx, input logic [KEY_W-1:0] k);
        int top;
        top = (idx >= MAX_KEYS) ? MAX_KEYS - 1 : idx;
        for (int i = top; i > 0; i--) begin
            order_keys[i] = order_keys[i-1];
        end
        order_keys[0] = k;
    endfunction

    task automatic predict_lru_answer(input t_req r);
        t_rsp a;
        int   hit;
        bit   created;
        a = '0;
        a.last = 1'b1;
        created = (capacity >= MIN_CAPACITY) && (capacity <= MAX_KEYS);
        hit = held_count;
        for (int i = 0; i < held_count; i++) begin
            if (order_keys[i] == r.key && hit == held_count) begin
                hit = i;
            end
        end
        if (r.command > CMD_FLUSH) begin
            return;
        end
        if (r.command == CMD_FLUSH) begin
            held_count = 0;
            pending_answers.push_back(a);
        end else if (!created) begin
            a.status = ST_NOT_CREATED;
            pending_answers.push_back(a);
        end else if (r.command == CMD_LIST) begin
            if (held_count == 0) begin
                pending_answers.push_back(a);
            end else begin
                for (int i = 0; i < held_count; i++) begin
                    a = '0;
                    a.position = POS_W'(i + 1);
                    a.list_key = order_keys[i];
                    a.last = (i == held_count - 1);
                    pending_answers.push_back(a);
                end
            end
        end else if (r.key > LAST_KEY) begin
            a.status = ST_BAD_KEY;
            pending_answers.push_back(a);
        end else if (r.command == CMD_ADD) begin
            if (hit == held_count) begin
                if (held_count >= capacity && held_count > 0) begin
                    a.evicted = 1'b1;
                    a.evicted_key = order_keys[held_count-1];
                    held_count--;
                end
                hit = held_count;
                if (held_count < MAX_KEYS) begin
                    held_count++;
                end
            end
            move_to_front(hit, r.key);
            a.position = POS_W'(1);
            pending_answers.push_back(a);
        end else if (hit == held_count) begin
            a.status = ST_NOT_FOUND;
            pending_answers.push_back(a);
        end else if (r.command == CMD_GET) begin
            move_to_front(hit, r.key);
            a.position = POS_W'(1);
            pending_answers.push_back(a);
        end else begin
            a.position = POS_W'(hit + 1);
            pending_answers.push_back(a);
        end
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report_failure($sformatf("mismatch on %s: got %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic check_answer(input t_rsp got);
        t_rsp want;
        if (pending_answers.size() == 0) begin
            report_failure($sformatf("response %h arrived with no request outstanding", got));
            return;
        end
        want = pending_answers.pop_front();
        compare_field("status", got.status, want.status);
        compare_field("position", got.position, want.position);
        compare_field("evicted", got.evicted, want.evicted);
        compare_field("evicted_key", got.evicted_key, want.evicted_key);
        compare_field("list_key", got.list_key, want.list_key);
        compare_field("last", got.last, want.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity = '0;
            held_count = 0;
            pending_answers.delete();
        end else begin
            if (i_cfg_we) begin
                capacity = i_cfg_wdata;
                held_count = 0;
            end
            if (i_req.valid && i_req.ready) begin
                predict_lru_answer(i_req.data);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                check_answer(i_rsp.data);
            end
        end
        o_outstanding <= pending_answers.size();
    end

endmodule

[bench/lru_recency_list_tb.sv]
`timescale 1ns / 1ps

module lru_recency_list_tb;
    import lrl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int MAX_GAP        = 18;
    localparam int LONG_HOLD      = 250;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 50;
    localparam int PHASE_COUNT    = 9;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    int               error_count;
    int               outstanding;
    int               sent_count = 0;
    int               setting_count = 0;
    bit               fast_mode = 1'b0;
    bit               hold_off_req = 1'b0;

    lrl_req_if req_bus ();
    lrl_rsp_if rsp_bus ();

    lru_recency_list #(
        .MAX_ENTRIES(16)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    lru_recency_checker #(
        .MAX_KEYS(16)
    ) u_lru_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_errors     (error_count),
        .o_outstanding(outstanding)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data <= '{command: cmd, key: key};
        do @(posedge i_clk); while (!(req_bus.valid && req_bus.ready));
        if (cmd <= CMD_FLUSH) begin
            sent_count++;
        end
    endtask

    task automatic wait_for_idle();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_for_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    task automatic send_random_request(input int key_span);
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            cmd = CMD_ADD;
        end else if (pick < 64) begin
            cmd = CMD_GET;
        end else if (pick < 80) begin
            cmd = CMD_SEARCH;
        end else if (pick < 91) begin
            cmd = CMD_LIST;
        end else if (pick < 95) begin
            cmd = CMD_FLUSH;
        end else begin
            cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end
        if ($urandom_range(0, 19) == 0) begin
            key = KEY_W'($urandom_range(0, 31));
        end else begin
            key = KEY_W'($urandom_range(0, key_span));
        end
        send_request(cmd, key);
    endtask

    initial begin
        int stall;
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_bus.valid && rsp_bus.ready));
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no request or response moved for %0d cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int               phase_target;
        int               key_span;
        logic [CAP_W-1:0] cap;
        req_bus.valid <= 1'b0;
        req_bus.data <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The cache starts out not created; flush is still answered.
        send_request(CMD_ADD, 5'd0);
        send_request(CMD_LIST, 5'd0);
        send_request(CMD_SEARCH, 5'd31);
        send_request(CMD_FLUSH, 5'd0);

        write_capacity(5'd5);
        send_request(CMD_LIST, 5'd0);
        send_request(CMD_ADD, 5'd26);
        send_request(CMD_GET, 5'd31);
        send_request(CMD_GET, 5'd3);
        send_request(CMD_SEARCH, 5'd3);
        send_request(CMD_ADD, 5'd0);
        send_request(CMD_ADD, 5'd25);
        send_request(CMD_ADD, 5'd1);
        send_request(CMD_ADD, 5'd2);
        send_request(CMD_ADD, 5'd3);
        send_request(CMD_ADD, 5'd4);
        send_request(CMD_ADD, 5'd1);
        send_request(CMD_GET, 5'd25);
        send_request(CMD_SEARCH, 5'd2);
        send_request(CMD_SEARCH, 5'd0);
        send_request(CMD_LIST, 5'd0);
        send_request(CMD_SPARE_LO, 5'd0);
        send_request(CMD_SPARE_HI, 5'd31);
        send_request(CMD_FLUSH, 5'd0);
        send_request(CMD_LIST, 5'd0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: cap = 5'd16;
                1: cap = 5'd31;
                2: cap = 5'd8;
                3: cap = 5'd5;
                4: cap = 5'd17;
                5: cap = 5'd12;
                6: cap = 5'd4;
                7: cap = 5'd16;
                default: cap = 5'd6;
            endcase
            write_capacity(cap);
            key_span = (cap <= 5'd16) ? cap + 4 : 20;
            fast_mode = (p == 3) || (p == 7);
            if (p == 0) begin
                hold_off_req = 1'b1;
            end
            phase_target = sent_count + PHASE_ITEMS;
            while (sent_count < phase_target) begin
                if (p == 5 && sent_count == phase_target - PHASE_ITEMS / 2) begin
                    wait_for_idle();
                end
                send_random_request(key_span);
            end
        end
        fast_mode = 1'b0;
        wait_for_idle();

        $display("Summary: %0d requests over %0d capacity settings, with hits, misses,",
                 sent_count, setting_count);
        $display("evictions, lists, flushes, bad keys, unused codes and not-created cases.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
